>>> hw/rtl/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types, constants and helpers of the three-component vector ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int NL        = 3;
  localparam int P_W       = 2 * Q_W;
  localparam int SAT_W     = P_W + 3;
  localparam int SQ_W      = P_W;
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int REM_W     = Q_W + 2;
  localparam int DIV_W     = Q_W + FRAC_BITS;
  localparam int DIV_LAT   = DIV_W + 2;

  localparam logic signed [Q_W-1:0]   Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(Q_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(Q_MIN);

  typedef enum logic [3:0] {
    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_SCALE, FN_DIVSCALE, FN_NEG, FN_DOT,
    FN_CROSS, FN_LEN, FN_NORM, FN_DIST, FN_LERP, FN_REFLECT, FN_MID
  } func_e;

  typedef logic [NL-1:0][Q_W-1:0] vec_t;

  typedef struct packed {
    logic                  flt;
    logic signed [Q_W-1:0] val;
  } sat_t;

  // lane front end output: raw products plus what later stages need
  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] q;
    logic signed [Q_W-1:0] pre;
    logic                  pf;
    logic signed [Q_W-1:0] a;
    logic signed [Q_W-1:0] b;
    logic signed [Q_W-1:0] dvs;
  } lane_t;

  typedef struct packed {
    func_e          op;
    vec_t           r;
    logic           flt;
    logic [Q_W-1:0] sc;
    vec_t           a;
    vec_t           dvs;
  } sq_side_t;

  typedef struct packed {
    func_e          op;
    vec_t           r;
    logic           flt;
    logic [Q_W-1:0] sc;
    logic           lz;
  } dv_side_t;

  function automatic sat_t sat_q(input logic signed [SAT_W-1:0] v);
    sat_t s;
    s.flt = 1'b0;
    s.val = v[Q_W-1:0];
    if (v > SAT_HI) begin
      s.flt = 1'b1;
      s.val = Q_MAX;
    end else if (v < SAT_LO) begin
      s.flt = 1'b1;
      s.val = Q_MIN;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/v3alu_lane.sv
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: operand select, add/sub/neg/mid, and the registered
// pair of 32x32 multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_lane (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  v3alu_pkg::func_e                         op_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    a_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    b_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    a1_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    b1_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    a2_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    b2_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]    s_i,
  output v3alu_pkg::lane_t                         lane_o
);

  logic signed [v3alu_pkg::SAT_W-1:0] sum_w, dab_w, dba_w, neg_w;
  v3alu_pkg::sat_t add_s, ab_s, ba_s, neg_s;

  logic signed [v3alu_pkg::Q_W-1:0] x_d, y_d, u_d, v_d, pre_d, dvs_d;
  logic                             pf_d;
  logic signed [v3alu_pkg::Q_W-1:0] x_q, y_q, u_q, v_q, pre_q, a_q, b_q, dvs_q;
  logic                             pf_q;
  v3alu_pkg::lane_t                 lane_q;

  assign sum_w = v3alu_pkg::SAT_W'(a_i) + v3alu_pkg::SAT_W'(b_i);
  assign dab_w = v3alu_pkg::SAT_W'(a_i) - v3alu_pkg::SAT_W'(b_i);
  assign dba_w = v3alu_pkg::SAT_W'(b_i) - v3alu_pkg::SAT_W'(a_i);
  assign neg_w = -v3alu_pkg::SAT_W'(a_i);

  assign add_s = v3alu_pkg::sat_q(sum_w);
  assign ab_s  = v3alu_pkg::sat_q(dab_w);
  assign ba_s  = v3alu_pkg::sat_q(dba_w);
  assign neg_s = v3alu_pkg::sat_q(neg_w);

  always_comb begin
    x_d   = a_i;
    y_d   = b_i;
    u_d   = '0;
    v_d   = '0;
    pre_d = '0;
    pf_d  = 1'b0;
    dvs_d = b_i;
    case (op_i)
      v3alu_pkg::FN_ADD: begin
        pre_d = add_s.val;
        pf_d  = add_s.flt;
      end
      v3alu_pkg::FN_SUB: begin
        pre_d = ab_s.val;
        pf_d  = ab_s.flt;
      end
      v3alu_pkg::FN_NEG: begin
        pre_d = neg_s.val;
        pf_d  = neg_s.flt;
      end
      v3alu_pkg::FN_MID:      pre_d = sum_w[v3alu_pkg::Q_W:1];
      v3alu_pkg::FN_SCALE:    y_d = s_i;
      v3alu_pkg::FN_DIVSCALE: dvs_d = s_i;
      v3alu_pkg::FN_CROSS: begin
        x_d = a1_i;
        y_d = b2_i;
        u_d = a2_i;
        v_d = b1_i;
      end
      v3alu_pkg::FN_LEN, v3alu_pkg::FN_NORM: y_d = a_i;
      v3alu_pkg::FN_DIST: begin
        x_d  = ab_s.val;
        y_d  = ab_s.val;
        pf_d = ab_s.flt;
      end
      v3alu_pkg::FN_LERP: begin
        x_d  = ba_s.val;
        y_d  = s_i;
        pf_d = ba_s.flt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      u_q   <= u_d;
      v_q   <= v_d;
      pre_q <= pre_d;
      pf_q  <= pf_d;
      a_q   <= a_i;
      b_q   <= b_i;
      dvs_q <= dvs_d;
      lane_q.p   <= v3alu_pkg::P_W'(x_q) * v3alu_pkg::P_W'(y_q);
      lane_q.q   <= v3alu_pkg::P_W'(u_q) * v3alu_pkg::P_W'(v_q);
      lane_q.pre <= pre_q;
      lane_q.pf  <= pf_q;
      lane_q.a   <= a_q;
      lane_q.b   <= b_q;
      lane_q.dvs <= dvs_q;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

>>> hw/rtl/v3alu_isqrt.sv
// ----------------------------------------------------------------------------
// v3alu_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_isqrt (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [v3alu_pkg::SQ_W-1:0]      rad_i,
  output logic      [v3alu_pkg::Q_W-1:0]       root_o
);

  logic [v3alu_pkg::REM_W-1:0] rem_q  [v3alu_pkg::SQ_STEPS];
  logic [v3alu_pkg::Q_W-1:0]   root_q [v3alu_pkg::SQ_STEPS];
  logic [v3alu_pkg::SQ_W-1:0]  rad_q  [v3alu_pkg::SQ_STEPS];

  for (genvar j = 0; j < v3alu_pkg::SQ_STEPS; j++) begin : g_stage
    logic [v3alu_pkg::REM_W-1:0] rem_in, remn, trial;
    logic [v3alu_pkg::Q_W-1:0]   root_in;
    logic [v3alu_pkg::SQ_W-1:0]  rad_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    // bring down the next bit pair, try root*4+1
    assign remn  = {rem_in[v3alu_pkg::REM_W-3:0], rad_in[v3alu_pkg::SQ_W-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j] <= {rad_in[v3alu_pkg::SQ_W-3:0], 2'b00};
        if (remn >= trial) begin
          rem_q[j]  <= remn - trial;
          root_q[j] <= {root_in[v3alu_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= remn;
          root_q[j] <= {root_in[v3alu_pkg::Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[v3alu_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

>>> hw/rtl/v3alu_div.sv
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero, saturated; a zero divisor returns the limit of num's sign.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_div (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  num_i,
  input  wire logic signed [v3alu_pkg::Q_W:0]    den_i,
  output logic signed      [v3alu_pkg::Q_W-1:0]  quo_o,
  output logic                                   flt_o
);

  localparam int NS = v3alu_pkg::DIV_W + 1;

  logic [v3alu_pkg::Q_W-1:0]   nmag, dmag;
  logic [v3alu_pkg::Q_W:0]     dabs;
  logic [v3alu_pkg::DIV_W-1:0] n_q   [NS];
  logic [v3alu_pkg::Q_W-1:0]   r_q   [NS];
  logic [v3alu_pkg::Q_W-1:0]   d_q   [NS];
  logic                        neg_q [NS];
  logic                        dz_q  [NS];
  logic                        pos_q [NS];

  logic [v3alu_pkg::DIV_W-1:0] q_mag, lim_pos;
  logic signed [v3alu_pkg::Q_W-1:0] quo_d, quo_q;
  logic                        flt_d, flt_q;

  assign nmag = num_i[v3alu_pkg::Q_W-1] ? v3alu_pkg::Q_W'(-num_i) : num_i;
  assign dabs = den_i[v3alu_pkg::Q_W] ? -den_i : den_i;
  assign dmag = dabs[v3alu_pkg::Q_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= {nmag, {v3alu_pkg::FRAC_BITS{1'b0}}};
      r_q[0]   <= '0;
      d_q[0]   <= dmag;
      neg_q[0] <= num_i[v3alu_pkg::Q_W-1] ^ den_i[v3alu_pkg::Q_W];
      dz_q[0]  <= (den_i == '0);
      pos_q[0] <= !num_i[v3alu_pkg::Q_W-1];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < v3alu_pkg::DIV_W; j++) begin : g_step
    logic [v3alu_pkg::Q_W:0] remn, dif;
    logic                    ge;

    assign remn = {r_q[j], n_q[j][v3alu_pkg::DIV_W-1]};
    assign dif  = remn - {1'b0, d_q[j]};
    assign ge   = (remn >= {1'b0, d_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1]   <= {n_q[j][v3alu_pkg::DIV_W-2:0], ge};
        r_q[j+1]   <= ge ? dif[v3alu_pkg::Q_W-1:0] : remn[v3alu_pkg::Q_W-1:0];
        d_q[j+1]   <= d_q[j];
        neg_q[j+1] <= neg_q[j];
        dz_q[j+1]  <= dz_q[j];
        pos_q[j+1] <= pos_q[j];
      end
    end
  end

  assign q_mag   = n_q[NS-1];
  assign lim_pos = v3alu_pkg::DIV_W'($unsigned(v3alu_pkg::Q_MAX));

  always_comb begin
    flt_d = 1'b0;
    quo_d = q_mag[v3alu_pkg::Q_W-1:0];
    if (dz_q[NS-1]) begin
      flt_d = 1'b1;
      quo_d = pos_q[NS-1] ? v3alu_pkg::Q_MAX : v3alu_pkg::Q_MIN;
    end else if (neg_q[NS-1]) begin
      if (q_mag > lim_pos + v3alu_pkg::DIV_W'(1)) begin
        flt_d = 1'b1;
        quo_d = v3alu_pkg::Q_MIN;
      end else begin
        quo_d = -q_mag[v3alu_pkg::Q_W-1:0];
      end
    end else if (q_mag > lim_pos) begin
      flt_d = 1'b1;
      quo_d = v3alu_pkg::Q_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
      flt_q <= flt_d;
    end
  end

  assign quo_o = quo_q;
  assign flt_o = flt_q;

endmodule

`default_nettype wire

>>> hw/rtl/vec3_alu_core.sv
// ----------------------------------------------------------------------------
// vec3_alu_core
// Three-component Q16.16 vector ALU, fully pipelined.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock while the output is not stalled
// and returns one result per transaction, in order. The Q16.16 datapath runs
// through the 32-stage square-root pipeline followed by the per-lane divider
// pipeline of 32 + FRAC_BITS + 2 stages; every operation passes through both
// so that results leave in order. A stall on the output while a result is
// held freezes the whole pipeline and shows up on in_stall_o in the same
// cycle.
`default_nettype none

module vec3_alu_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [3:0]                        func_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  a_x_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  a_y_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  a_z_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  b_x_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  b_y_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  b_z_i,
  input  wire logic signed [v3alu_pkg::Q_W-1:0]  scalar_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [v3alu_pkg::Q_W-1:0]       r_x_o,
  output logic signed [v3alu_pkg::Q_W-1:0]       r_y_o,
  output logic signed [v3alu_pkg::Q_W-1:0]       r_z_o,
  output logic signed [v3alu_pkg::Q_W-1:0]       r_scalar_o,
  output logic                                   fault_o
);

  localparam int SQL = v3alu_pkg::SQ_STEPS;
  localparam int DVL = v3alu_pkg::DIV_LAT;

  logic             en;
  v3alu_pkg::func_e op_in;
  v3alu_pkg::vec_t  av, bv;

  logic             v1_q, v2_q, v3_q, v4_q;
  v3alu_pkg::func_e op1_q, op2_q, op3_q, op4_q;

  v3alu_pkg::lane_t ln [v3alu_pkg::NL];

  // merge stage
  v3alu_pkg::vec_t                  r3_d, r3_q, a3_q, b3_q, dvs3_q;
  logic                             f3_d, f3_q;
  logic [v3alu_pkg::Q_W-1:0]        sc3_d, sc3_q;
  logic signed [v3alu_pkg::Q_W-1:0] k3_d, k3_q;
  logic [v3alu_pkg::SQ_W-1:0]       sq3_d, sq3_q;
  logic signed [v3alu_pkg::SAT_W-1:0] dsum;
  v3alu_pkg::sat_t                  dsat, ksat, t0, t1, tc;

  // reflect product stage
  logic signed [v3alu_pkg::P_W-1:0] p4_q [v3alu_pkg::NL];
  v3alu_pkg::vec_t                  r4_q, a4_q, dvs4_q;
  logic                             f4_q;
  logic [v3alu_pkg::Q_W-1:0]        sc4_q;
  logic [v3alu_pkg::SQ_W-1:0]       sq4_q;
  v3alu_pkg::sat_t                  rm, rr;

  // square-root and divider side carry
  v3alu_pkg::sq_side_t              sd_in;
  logic                             sq_v_q  [SQL];
  v3alu_pkg::sq_side_t              sq_sd_q [SQL];
  logic [v3alu_pkg::Q_W-1:0]        root;
  v3alu_pkg::sq_side_t              sl;
  v3alu_pkg::dv_side_t              dv_in;
  logic signed [v3alu_pkg::Q_W:0]   den [v3alu_pkg::NL];
  logic signed [v3alu_pkg::Q_W-1:0] dq  [v3alu_pkg::NL];
  logic                             dfl [v3alu_pkg::NL];
  logic                             dv_v_q  [DVL];
  v3alu_pkg::dv_side_t              dv_sd_q [DVL];
  v3alu_pkg::dv_side_t              dl;

  v3alu_pkg::vec_t                  fin_r, r_q;
  logic                             fin_f, fault_q, out_valid_q;
  logic [v3alu_pkg::Q_W-1:0]        fin_sc, sc_q;

  // whole pipeline moves together; the output register decides
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign op_in      = v3alu_pkg::func_e'(func_i);
  assign av         = {a_z_i, a_y_i, a_x_i};
  assign bv         = {b_z_i, b_y_i, b_x_i};

  for (genvar i = 0; i < v3alu_pkg::NL; i++) begin : g_lane
    v3alu_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .op_i   (op_in),
      .a_i    ($signed(av[i])),
      .b_i    ($signed(bv[i])),
      .a1_i   ($signed(av[(i+1) % v3alu_pkg::NL])),
      .b1_i   ($signed(bv[(i+1) % v3alu_pkg::NL])),
      .a2_i   ($signed(av[(i+2) % v3alu_pkg::NL])),
      .b2_i   ($signed(bv[(i+2) % v3alu_pkg::NL])),
      .s_i    (scalar_in_i),
      .lane_o (ln[i])
    );
  end

  // merge: per-lane product results plus the dot/length sums across lanes
  always_comb begin
    r3_d  = '0;
    f3_d  = 1'b0;
    sc3_d = '0;
    k3_d  = '0;
    dsum  = v3alu_pkg::SAT_W'(ln[0].p) + v3alu_pkg::SAT_W'(ln[1].p)
          + v3alu_pkg::SAT_W'(ln[2].p);
    dsat  = v3alu_pkg::sat_q(dsum >>> v3alu_pkg::FRAC_BITS);
    ksat  = v3alu_pkg::sat_q(v3alu_pkg::SAT_W'($signed(dsat.val))
          + v3alu_pkg::SAT_W'($signed(dsat.val)));
    sq3_d = v3alu_pkg::SQ_W'($unsigned(ln[0].p)) + v3alu_pkg::SQ_W'($unsigned(ln[1].p))
          + v3alu_pkg::SQ_W'($unsigned(ln[2].p));
    t0    = '0;
    t1    = '0;
    tc    = '0;
    for (int i = 0; i < v3alu_pkg::NL; i++) begin
      t0 = v3alu_pkg::sat_q(v3alu_pkg::SAT_W'(ln[i].p) >>> v3alu_pkg::FRAC_BITS);
      t1 = v3alu_pkg::sat_q(v3alu_pkg::SAT_W'($signed(ln[i].a))
         + v3alu_pkg::SAT_W'($signed(t0.val)));
      tc = v3alu_pkg::sat_q((v3alu_pkg::SAT_W'(ln[i].p) - v3alu_pkg::SAT_W'(ln[i].q))
         >>> v3alu_pkg::FRAC_BITS);
      case (op2_q)
        v3alu_pkg::FN_ADD, v3alu_pkg::FN_SUB, v3alu_pkg::FN_NEG, v3alu_pkg::FN_MID: begin
          r3_d[i] = ln[i].pre;
          f3_d    = f3_d | ln[i].pf;
        end
        v3alu_pkg::FN_MUL, v3alu_pkg::FN_SCALE: begin
          r3_d[i] = t0.val;
          f3_d    = f3_d | t0.flt;
        end
        v3alu_pkg::FN_LERP: begin
          r3_d[i] = t1.val;
          f3_d    = f3_d | ln[i].pf | t0.flt | t1.flt;
        end
        v3alu_pkg::FN_CROSS: begin
          r3_d[i] = tc.val;
          f3_d    = f3_d | tc.flt;
        end
        v3alu_pkg::FN_DIST: f3_d = f3_d | ln[i].pf;
        default: ;
      endcase
    end
    case (op2_q)
      v3alu_pkg::FN_DOT: begin
        sc3_d = dsat.val;
        f3_d  = f3_d | dsat.flt;
      end
      v3alu_pkg::FN_REFLECT: begin
        k3_d = ksat.val;
        f3_d = f3_d | dsat.flt | ksat.flt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op_in;
      op2_q <= op1_q;
      op3_q <= op2_q;
      op4_q <= op3_q;
      r3_q  <= r3_d;
      f3_q  <= f3_d;
      sc3_q <= sc3_d;
      k3_q  <= k3_d;
      sq3_q <= sq3_d;
      for (int i = 0; i < v3alu_pkg::NL; i++) begin
        a3_q[i]   <= ln[i].a;
        b3_q[i]   <= ln[i].b;
        dvs3_q[i] <= ln[i].dvs;
        p4_q[i]   <= v3alu_pkg::P_W'($signed(b3_q[i])) * v3alu_pkg::P_W'(k3_q);
      end
      r4_q   <= r3_q;
      a4_q   <= a3_q;
      dvs4_q <= dvs3_q;
      f4_q   <= f3_q;
      sc4_q  <= sc3_q;
      sq4_q  <= sq3_q;
    end
  end

  // reflect: a - b * k
  always_comb begin
    sd_in.op  = op4_q;
    sd_in.r   = r4_q;
    sd_in.flt = f4_q;
    sd_in.sc  = sc4_q;
    sd_in.a   = a4_q;
    sd_in.dvs = dvs4_q;
    rm        = '0;
    rr        = '0;
    if (op4_q == v3alu_pkg::FN_REFLECT) begin
      for (int i = 0; i < v3alu_pkg::NL; i++) begin
        rm = v3alu_pkg::sat_q(v3alu_pkg::SAT_W'(p4_q[i]) >>> v3alu_pkg::FRAC_BITS);
        rr = v3alu_pkg::sat_q(v3alu_pkg::SAT_W'($signed(a4_q[i]))
           - v3alu_pkg::SAT_W'($signed(rm.val)));
        sd_in.r[i] = rr.val;
        sd_in.flt  = sd_in.flt | rm.flt | rr.flt;
      end
    end
  end

  v3alu_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq4_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SQL; j++) sq_v_q[j] <= 1'b0;
      for (int j = 0; j < DVL; j++) dv_v_q[j] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= v4_q;
      for (int j = 1; j < SQL; j++) sq_v_q[j] <= sq_v_q[j-1];
      dv_v_q[0] <= sq_v_q[SQL-1];
      for (int j = 1; j < DVL; j++) dv_v_q[j] <= dv_v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_sd_q[0] <= sd_in;
      for (int j = 1; j < SQL; j++) sq_sd_q[j] <= sq_sd_q[j-1];
      dv_sd_q[0] <= dv_in;
      for (int j = 1; j < DVL; j++) dv_sd_q[j] <= dv_sd_q[j-1];
    end
  end

  assign sl = sq_sd_q[SQL-1];

  // length results and divider operands
  always_comb begin
    dv_in.op  = sl.op;
    dv_in.r   = sl.r;
    dv_in.flt = sl.flt;
    dv_in.sc  = sl.sc;
    dv_in.lz  = (root == '0);
    if (sl.op == v3alu_pkg::FN_LEN || sl.op == v3alu_pkg::FN_DIST) begin
      if (root[v3alu_pkg::Q_W-1]) begin
        dv_in.sc  = v3alu_pkg::Q_MAX;
        dv_in.flt = 1'b1;
      end else begin
        dv_in.sc  = root;
      end
    end
    for (int i = 0; i < v3alu_pkg::NL; i++) begin
      if (sl.op == v3alu_pkg::FN_NORM) begin
        den[i] = $signed({1'b0, root});
      end else begin
        den[i] = $signed({sl.dvs[i][v3alu_pkg::Q_W-1], sl.dvs[i]});
      end
    end
  end

  for (genvar i = 0; i < v3alu_pkg::NL; i++) begin : g_div
    v3alu_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ($signed(sl.a[i])),
      .den_i (den[i]),
      .quo_o (dq[i]),
      .flt_o (dfl[i])
    );
  end

  assign dl = dv_sd_q[DVL-1];

  always_comb begin
    fin_r  = dl.r;
    fin_f  = dl.flt;
    fin_sc = dl.sc;
    case (dl.op)
      v3alu_pkg::FN_DIV, v3alu_pkg::FN_DIVSCALE: begin
        for (int i = 0; i < v3alu_pkg::NL; i++) begin
          fin_r[i] = dq[i];
          fin_f    = fin_f | dfl[i];
        end
      end
      v3alu_pkg::FN_NORM: begin
        // a zero-length vector normalizes to zero without a fault
        if (!dl.lz) begin
          for (int i = 0; i < v3alu_pkg::NL; i++) begin
            fin_r[i] = dq[i];
            fin_f    = fin_f | dfl[i];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v_q[DVL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q     <= fin_r;
      sc_q    <= fin_sc;
      fault_q <= fin_f;
    end
  end

  assign out_valid_o = out_valid_q;
  assign r_x_o       = $signed(r_q[0]);
  assign r_y_o       = $signed(r_q[1]);
  assign r_z_o       = $signed(r_q[2]);
  assign r_scalar_o  = $signed(sc_q);
  assign fault_o     = fault_q;

  // scalar operations leave the vector zero
  a_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DVL-1] && (dl.op == v3alu_pkg::FN_DOT || dl.op == v3alu_pkg::FN_LEN
      || dl.op == v3alu_pkg::FN_DIST)) |-> (fin_r == '0))
    else $error("vector result not zero for scalar operation");

  // vector operations leave the scalar zero
  a_sc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DVL-1] && dl.op != v3alu_pkg::FN_DOT && dl.op != v3alu_pkg::FN_LEN
      && dl.op != v3alu_pkg::FN_DIST) |-> (fin_sc == '0))
    else $error("scalar result not zero for vector operation");

  a_norm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DVL-1] && dl.op == v3alu_pkg::FN_NORM && dl.lz) |-> (!fin_f && fin_r == '0))
    else $error("zero-length normalize raised fault or nonzero result");

  // a stalled output freezes the transactions in flight
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sq_v_q[0]) && $stable(dv_v_q[0]) && $stable(v4_q)))
    else $error("pipeline advanced while stalled");

endmodule

`default_nettype wire

>>> tb/vec3_alu_checker.sv
// ----------------------------------------------------------------------------
// vec3_alu_checker
// Watches both channels of the vector ALU, computes the expected result of
// every accepted transaction and compares it with what the core returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vec3_alu_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [3:0]  func_i,
  input  wire logic [31:0] a_x_i,
  input  wire logic [31:0] a_y_i,
  input  wire logic [31:0] a_z_i,
  input  wire logic [31:0] b_x_i,
  input  wire logic [31:0] b_y_i,
  input  wire logic [31:0] b_z_i,
  input  wire logic [31:0] scalar_in_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] r_x_i,
  input  wire logic [31:0] r_y_i,
  input  wire logic [31:0] r_z_i,
  input  wire logic [31:0] r_scalar_i,
  input  wire logic        fault_i,
  output int               errors_o,
  output int               pending_o
);

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;

  typedef struct {
    logic [31:0] x, y, z, s;
    logic        f;
  } alu_result_t;

  alu_result_t result_q[$];

  // saturate a 128-bit value to Q range
  function automatic longint clamp(input logic signed [127:0] v, ref bit f);
    if (v > QHI) begin
      f = 1;
      return QHI;
    end
    if (v < QLO) begin
      f = 1;
      return QLO;
    end
    return longint'(v);
  endfunction

  // arithmetic shift is a floor
  function automatic longint qmul(input longint a, input longint b, ref bit f);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return clamp(p >>> v3alu_pkg::FRAC_BITS, f);
  endfunction

  function automatic longint qdiv(input longint a, input longint b, ref bit f);
    logic signed [127:0] n;
    if (b == 0) begin
      f = 1;
      return (a >= 0) ? QHI : QLO;
    end
    n = 128'(a) <<< v3alu_pkg::FRAC_BITS;
    return clamp(n / 128'(b), f);
  endfunction

  function automatic logic [63:0] sqrt_floor(input logic [127:0] v);
    logic [127:0] r, t;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= v) r = t;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] vlen(input longint v[3]);
    logic [127:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += 128'(128'(v[i]) * 128'(v[i]));
    return sqrt_floor(s);
  endfunction

  function automatic longint vdot(input longint a[3], input longint b[3], ref bit f);
    logic signed [127:0] s;
    s = 128'(a[0]) * 128'(b[0]) + 128'(a[1]) * 128'(b[1]) + 128'(a[2]) * 128'(b[2]);
    return clamp(s >>> v3alu_pkg::FRAC_BITS, f);
  endfunction

  function automatic alu_result_t alu_predict(input logic [3:0] fn, input logic [31:0] ax,
      input logic [31:0] ay, input logic [31:0] az, input logic [31:0] bx,
      input logic [31:0] by, input logic [31:0] bz, input logic [31:0] sv);
    longint a[3], b[3], r[3], d[3], s, sc, k;
    logic [63:0] len;
    logic signed [127:0] t;
    bit f;
    alu_result_t res;
    a[0] = longint'($signed(ax)); a[1] = longint'($signed(ay)); a[2] = longint'($signed(az));
    b[0] = longint'($signed(bx)); b[1] = longint'($signed(by)); b[2] = longint'($signed(bz));
    s = longint'($signed(sv));
    r = '{0, 0, 0};
    sc = 0;
    f = 0;
    case (fn)
      v3alu_pkg::FN_ADD:
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(a[i] + b[i]), f);
      v3alu_pkg::FN_SUB:
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(a[i] - b[i]), f);
      v3alu_pkg::FN_MUL:
        for (int i = 0; i < 3; i++) r[i] = qmul(a[i], b[i], f);
      v3alu_pkg::FN_DIV:
        for (int i = 0; i < 3; i++) r[i] = qdiv(a[i], b[i], f);
      v3alu_pkg::FN_SCALE:
        for (int i = 0; i < 3; i++) r[i] = qmul(a[i], s, f);
      v3alu_pkg::FN_DIVSCALE:
        for (int i = 0; i < 3; i++) r[i] = qdiv(a[i], s, f);
      v3alu_pkg::FN_NEG:
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(-a[i]), f);
      v3alu_pkg::FN_DOT: sc = vdot(a, b, f);
      v3alu_pkg::FN_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t = 128'(a[(i+1)%3]) * 128'(b[(i+2)%3]) - 128'(a[(i+2)%3]) * 128'(b[(i+1)%3]);
          r[i] = clamp(t >>> v3alu_pkg::FRAC_BITS, f);
        end
      end
      v3alu_pkg::FN_LEN: sc = clamp(128'(vlen(a)), f);
      v3alu_pkg::FN_NORM: begin
        len = vlen(a);
        // zero-length vector stays zero without a fault
        if (len != 0)
          for (int i = 0; i < 3; i++)
            r[i] = clamp((128'(a[i]) <<< v3alu_pkg::FRAC_BITS) / $signed({64'd0, len}), f);
      end
      v3alu_pkg::FN_DIST: begin
        for (int i = 0; i < 3; i++) d[i] = clamp(128'(a[i] - b[i]), f);
        sc = clamp(128'(vlen(d)), f);
      end
      v3alu_pkg::FN_LERP: begin
        for (int i = 0; i < 3; i++) begin
          d[i] = clamp(128'(b[i] - a[i]), f);
          r[i] = clamp(128'(a[i] + qmul(d[i], s, f)), f);
        end
      end
      v3alu_pkg::FN_REFLECT: begin
        k = clamp(128'(2 * vdot(a, b, f)), f);
        for (int i = 0; i < 3; i++) r[i] = clamp(128'(a[i] - qmul(b[i], k, f)), f);
      end
      v3alu_pkg::FN_MID:
        for (int i = 0; i < 3; i++) r[i] = (a[i] + b[i]) >>> 1;
      default: ;
    endcase
    res.x = r[0][31:0]; res.y = r[1][31:0]; res.z = r[2][31:0];
    res.s = sc[31:0];
    res.f = f;
    return res;
  endfunction

  initial errors_o = 0;

  always @(posedge clk_i) begin
    alu_result_t e;
    if (rst_ni && in_valid_i && !in_stall_i)
      result_q.push_back(alu_predict(func_i, a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i,
                                     scalar_in_i));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors_o <= errors_o + 1;
      end else begin
        e = result_q.pop_front();
        if (e.x !== r_x_i || e.y !== r_y_i || e.z !== r_z_i || e.s !== r_scalar_i
            || e.f !== fault_i) begin
          if (e.x !== r_x_i) $error("r_x expected %h actual %h", e.x, r_x_i);
          if (e.y !== r_y_i) $error("r_y expected %h actual %h", e.y, r_y_i);
          if (e.z !== r_z_i) $error("r_z expected %h actual %h", e.z, r_z_i);
          if (e.s !== r_scalar_i) $error("r_scalar expected %h actual %h", e.s, r_scalar_i);
          if (e.f !== fault_i) $error("fault expected %b actual %b", e.f, fault_i);
          errors_o <= errors_o + 1;
        end
      end
    end
    pending_o <= result_q.size();
  end

endmodule

>>> tb/vec3_alu_core_test.sv
// ----------------------------------------------------------------------------
// vec3_alu_core_test
// Drives directed corner cases and random transactions into the vector ALU
// under varying idle patterns and a long output hold-off; a checker beside
// the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vec3_alu_core_test;

  localparam int LIMIT = 400000;

  logic clk = 0, rst_ni = 0;
  logic in_valid = 0, out_stall = 0;
  logic [3:0] func = '0;
  logic [31:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0, scal = 0;
  logic in_stall, out_valid, fault;
  logic [31:0] r_x, r_y, r_z, r_s;
  int errors, pending, cycles = 0;
  int send_idle = 34, recv_idle = 84;
  bit holdoff = 0;

  always #1 clk = ~clk;

  vec3_alu_core DUT (
    .clk_i(clk), .rst_ni(rst_ni), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z), .b_x_i(b_x), .b_y_i(b_y),
    .b_z_i(b_z), .scalar_in_i(scal), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .r_x_o(r_x), .r_y_o(r_y), .r_z_o(r_z), .r_scalar_o(r_s), .fault_o(fault)
  );

  vec3_alu_checker u_checker (
    .clk_i(clk), .rst_ni(rst_ni), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z), .b_x_i(b_x), .b_y_i(b_y),
    .b_z_i(b_z), .scalar_in_i(scal), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .r_x_i(r_x), .r_y_i(r_y), .r_z_i(r_z), .r_scalar_i(r_s), .fault_i(fault),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= holdoff || ($urandom_range(99) < recv_idle);

  // corner-biased operand
  function automatic logic [31:0] rand_q();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5, 6: return 32'($signed($urandom_range(65535 * 4)) - 131070) <<< $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vec(input logic [3:0] fn, input logic [31:0] ax, input logic [31:0] ay,
      input logic [31:0] az, input logic [31:0] bx, input logic [31:0] by,
      input logic [31:0] bz, input logic [31:0] sv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    func <= fn; a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz; scal <= sv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [3:0] fn;
    fn = ($urandom_range(99) < 2) ? 4'hf : 4'($urandom_range(14));
    send_vec(fn, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
  endtask

  initial begin
    logic [31:0] mx, mn, one;
    mx = 32'h7fffffff; mn = 32'h80000000; one = 32'h00010000;
    repeat (11) @(posedge clk);
    rst_ni <= 1;
    @(posedge clk);
    for (int f = 0; f < 16; f++)
      send_vec(4'(f), one, 32'h00020000, mn, mx, 32'hfffe8000, one, 32'h00008000);
    send_vec(v3alu_pkg::FN_DIV, mx, mn, 0, 0, 0, 0, 0);
    send_vec(v3alu_pkg::FN_DIVSCALE, mn, 5, 0, 0, 0, 0, 0);
    send_vec(v3alu_pkg::FN_NORM, 0, 0, 0, one, one, one, one);
    send_vec(v3alu_pkg::FN_LEN, mn, mn, mn, 0, 0, 0, 0);
    send_vec(v3alu_pkg::FN_DIST, mx, mx, mx, mn, mn, mn, 0);
    send_vec(v3alu_pkg::FN_MUL, mn, mn, mx, mn, 0, mx, 0);
    send_vec(v3alu_pkg::FN_REFLECT, mx, mx, mx, mx, mx, mx, mx);
    send_vec(v3alu_pkg::FN_NEG, mn, mx, 0, 0, 0, 0, 0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 84 : 0;
      recv_idle = (ph == 0) ? 84 : (ph == 1) ? 34 : 0;
      for (int i = 0; i < 560; i++) begin
        if (ph == 2 && i == 100) begin
          // long hold-off: counted in its own process, sender keeps going
          fork
            begin
              holdoff = 1;
              repeat (300) @(posedge clk);
              holdoff = 0;
            end
          join_none
        end
        send_random();
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
